// ===== src/itsa_pkg.sv =====
// itsa_pkg: shared codes, types and search geometry for the id-to-slot allocator
// used by itsa_find and id_to_slot_allocator_core; no dependencies
`default_nettype none

package itsa_pkg;

  // default sizes
  localparam int unsigned SLOTS_DEF    = 128;
  localparam int unsigned ID_SPACE_DEF = 1024;

  // payload widths fixed by the interface
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned SLOT_W   = 7;

  // priority search geometry: groups of sixteen bits
  localparam int unsigned FIND_GW  = 16;
  localparam int unsigned FIND_GIW = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_KICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_KEEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_FREED     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_POLL_UPD  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_POLL_KICK = 4'd6;
  localparam logic [STATUS_W-1:0] ST_POLL_NONE = 4'd7;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 4'd8;

  // sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_HOLD
  } state_e;

endpackage

`default_nettype wire

// ===== src/itsa_find.sv =====
// itsa_find: two-stage lowest-set-bit search over a slot bitmap
// stage one registers per-group flags, stage two picks the lowest group; uses itsa_pkg
`default_nettype none

module itsa_find #(
  parameter int unsigned N = itsa_pkg::SLOTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic [N-1:0]         vec_i,
  output logic                      found_o,
  output logic [$clog2(N)-1:0]      idx_o
);

  localparam int unsigned SB  = $clog2(N);
  localparam int unsigned GW  = itsa_pkg::FIND_GW;
  localparam int unsigned GIW = itsa_pkg::FIND_GIW;
  localparam int unsigned NG  = (N + GW - 1) / GW;
  localparam int unsigned NGW = (NG > 1) ? $clog2(NG) : 1;

  logic [NG*GW-1:0]  pad;
  logic [GIW-1:0]    lo_c [NG];
  logic [NG-1:0]     any_q;
  logic [GIW-1:0]    lo_q [NG];
  logic [NGW+GIW-1:0] wide;

  assign pad = (NG*GW)'(vec_i);

  // lowest set bit inside each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      lo_c[g] = '0;
      for (int b = GW - 1; b >= 0; b--) begin
        if (pad[g*GW + b]) begin
          lo_c[g] = GIW'(b);
        end
      end
    end
  end

  // stage one registers
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NG; g++) begin
      any_q[g] <= |pad[g*GW +: GW];
      lo_q[g]  <= lo_c[g];
    end
  end

  // stage two: lowest non-empty group
  always_comb begin
    wide = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (any_q[g]) begin
        wide = {NGW'(g), lo_q[g]};
      end
    end
  end

  assign found_o = |any_q;
  assign idx_o   = wide[SB-1:0];

endmodule

`default_nettype wire

// ===== src/id_to_slot_allocator_core.sv =====
// id_to_slot_allocator_core: maps external ids to local slots, lowest free slot first
// holds the id map memory and slot bitmaps; uses itsa_pkg and itsa_find
//
// flow: a beat accepted in S_IDLE is read from the id map and decided in S_LOOK; its
//   result enters the output register from S_LOOK, or from S_HOLD while the output is
//   stalled; beats are taken one at a time (id map read, then modify and write back)
// reset: async active low; a clearing pass then walks the id map one entry a cycle,
//   all ID_SPACE entries with in_stall_o high, before the first beat is taken
`default_nettype none

module id_to_slot_allocator_core #(
  parameter int unsigned SLOTS    = itsa_pkg::SLOTS_DEF,
  parameter int unsigned ID_SPACE = itsa_pkg::ID_SPACE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [itsa_pkg::CMD_W-1:0]     in_cmd_i,
  input  wire logic [itsa_pkg::ID_W-1:0]      in_actor_id_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [itsa_pkg::STATUS_W-1:0]       out_status_o,
  output logic [itsa_pkg::SLOT_W-1:0]         out_slot_o,
  output logic                                out_more_pending_o
);

  localparam int unsigned SB  = $clog2(SLOTS);
  localparam int unsigned AW  = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int unsigned PCW = $clog2(SLOTS + 1);
  localparam int unsigned IDW = itsa_pkg::ID_W;
  localparam int unsigned SW  = itsa_pkg::SLOT_W;
  localparam int unsigned STW = itsa_pkg::STATUS_W;

  // sequencer
  itsa_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;

  // latched beat
  logic [itsa_pkg::CMD_W-1:0] cmd_q;
  logic [AW-1:0]              addr_q;
  logic                       oor_q;

  // id map memory: {valid, slot}
  logic [SB:0]   id_mem [ID_SPACE];
  logic [SB:0]   rd_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SB:0]   mem_wdata;

  // slot bitmaps and pending count
  logic [SLOTS-1:0] alive_q, alive_d;
  logic [SLOTS-1:0] upd_q, upd_d;
  logic [SLOTS-1:0] kick_q, kick_d;
  logic [PCW-1:0]   pend_q, pend_d;

  // search
  logic [SLOTS-1:0] free_vec, pend_vec, find_vec;
  logic             f_found;
  logic [SB-1:0]    f_idx;

  // result path
  logic           accept, out_free, do_look, load_out;
  logic [STW-1:0] calc_status, res_status_q;
  logic [SB-1:0]  calc_slot;
  logic           calc_more, res_more_q;
  logic [SW-1:0]  calc_slot_w, res_slot_q;
  logic [SB+SW-1:0] slot_ext;
  logic           out_valid_q;
  logic [STW-1:0] out_status_q;
  logic [SW-1:0]  out_slot_q;
  logic           out_more_q;

  // look-stage working signals
  logic          map_vld;
  logic [SB-1:0] map_slot;
  logic [SB-1:0] tgt;
  logic [SLOTS-1:0] sel;
  logic          was_none;

  logic [AW+IDW-1:0] id_ext;
  logic [31:0]       id_wide;

  assign id_ext  = {{AW{1'b0}}, in_actor_id_i};
  assign id_wide = {{(32-IDW){1'b0}}, in_actor_id_i};

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      itsa_pkg::S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(ID_SPACE - 1)) begin
          state_d = itsa_pkg::S_IDLE;
        end
      end
      itsa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = itsa_pkg::S_LOOK;
        end
      end
      itsa_pkg::S_LOOK: begin
        state_d = out_free ? itsa_pkg::S_IDLE : itsa_pkg::S_HOLD;
      end
      itsa_pkg::S_HOLD: begin
        if (out_free) begin
          state_d = itsa_pkg::S_IDLE;
        end
      end
      default: state_d = itsa_pkg::S_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    do_look    = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      itsa_pkg::S_CLEAR: begin
        in_stall_o = 1'b1;
      end
      itsa_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      itsa_pkg::S_LOOK: begin
        do_look  = 1'b1;
        load_out = out_free;
      end
      itsa_pkg::S_HOLD: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign mem_re = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itsa_pkg::S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // latch the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd_i;
      addr_q <= id_ext[AW-1:0];
      oor_q  <= (id_wide >= 32'(ID_SPACE));
    end
  end

  // search input: free slots for keep, pending marks for poll
  assign free_vec = ~alive_q & ~{{(SLOTS-1){1'b0}}, 1'b1};
  assign pend_vec = upd_q | kick_q;
  assign find_vec = (in_cmd_i == itsa_pkg::CMD_POLL) ? pend_vec : free_vec;

  itsa_find #(
    .N (SLOTS)
  ) u_find (
    .clk_i   (clk_i),
    .vec_i   (find_vec),
    .found_o (f_found),
    .idx_o   (f_idx)
  );

  assign map_vld  = rd_q[SB];
  assign map_slot = rd_q[SB-1:0];

  // modify step: decide result and state updates
  always_comb begin
    alive_d     = alive_q;
    upd_d       = upd_q;
    kick_d      = kick_q;
    pend_d      = pend_q;
    calc_status = itsa_pkg::ST_POLL_NONE;
    calc_slot   = '0;
    mem_we      = 1'b0;
    mem_wdata   = '0;
    tgt         = map_slot;
    case (cmd_q)
      itsa_pkg::CMD_POLL: tgt = f_idx;
      itsa_pkg::CMD_KEEP: tgt = map_vld ? map_slot : f_idx;
      default:            tgt = map_slot;
    endcase
    sel      = {{(SLOTS-1){1'b0}}, 1'b1} << tgt;
    was_none = !upd_q[tgt] && !kick_q[tgt];

    case (cmd_q)
      itsa_pkg::CMD_KICK: begin
        if (oor_q) begin
          calc_status = itsa_pkg::ST_RANGE;
        end else if (!map_vld) begin
          calc_status = itsa_pkg::ST_UNKNOWN;
        end else begin
          calc_status = itsa_pkg::ST_FREED;
          calc_slot   = tgt;
          mem_we      = do_look;
          mem_wdata   = '0;
          alive_d     = alive_q & ~sel;
          upd_d       = upd_q & ~sel;
          kick_d      = kick_q | sel;
          if (was_none) pend_d = pend_q + PCW'(1);
        end
      end
      itsa_pkg::CMD_KEEP: begin
        if (oor_q) begin
          calc_status = itsa_pkg::ST_RANGE;
        end else if (map_vld) begin
          calc_status = itsa_pkg::ST_UPDATED;
          calc_slot   = tgt;
          upd_d       = upd_q | sel;
          kick_d      = kick_q & ~sel;
          if (was_none) pend_d = pend_q + PCW'(1);
        end else if (!f_found) begin
          calc_status = itsa_pkg::ST_FULL;
        end else begin
          calc_status = itsa_pkg::ST_ADDED;
          calc_slot   = tgt;
          mem_we      = do_look;
          mem_wdata   = {1'b1, tgt};
          alive_d     = alive_q | sel;
          upd_d       = upd_q | sel;
          kick_d      = kick_q & ~sel;
          if (was_none) pend_d = pend_q + PCW'(1);
        end
      end
      itsa_pkg::CMD_POLL: begin
        if (f_found) begin
          calc_status = kick_q[tgt] ? itsa_pkg::ST_POLL_KICK : itsa_pkg::ST_POLL_UPD;
          calc_slot   = tgt;
          upd_d       = upd_q & ~sel;
          kick_d      = kick_q & ~sel;
          pend_d      = pend_q - PCW'(1);
        end
      end
      default: begin
        calc_status = itsa_pkg::ST_POLL_NONE;
      end
    endcase
    calc_more = (pend_d != '0);
  end

  assign slot_ext    = {{SW{1'b0}}, calc_slot};
  assign calc_slot_w = slot_ext[SW-1:0];

  // id map memory: clearing pass, write back, registered read
  assign mem_waddr = (state_q == itsa_pkg::S_CLEAR) ? clr_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (state_q == itsa_pkg::S_CLEAR) begin
      id_mem[mem_waddr] <= '0;
    end else if (mem_we) begin
      id_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= id_mem[id_ext[AW-1:0]];
    end
  end

  // slot bitmaps, committed once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '0;
      upd_q   <= '0;
      kick_q  <= '0;
      pend_q  <= '0;
    end else if (do_look) begin
      alive_q <= alive_d;
      upd_q   <= upd_d;
      kick_q  <= kick_d;
      pend_q  <= pend_d;
    end
  end

  // result hold while the output register is busy
  always_ff @(posedge clk_i) begin
    if (do_look) begin
      res_status_q <= calc_status;
      res_slot_q   <= calc_slot_w;
      res_more_q   <= calc_more;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= do_look ? calc_status : res_status_q;
      out_slot_q   <= do_look ? calc_slot_w : res_slot_q;
      out_more_q   <= do_look ? calc_more : res_more_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_slot_o         = out_slot_q;
  assign out_more_pending_o = out_more_q;

  // pending count tracks the marks
  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == PCW'($countones(upd_q | kick_q)))
    else $error("pending count out of step with marks");

  // a slot never holds both marks
  a_mark_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_q & kick_q) == '0)
    else $error("slot marked updated and kicked");

  // slot zero is never handed out
  a_slot0_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alive_q[0])
    else $error("slot zero allocated");

  // a finished beat is never dropped from the output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
